// ===== sv/rxf_pkg.sv =====
// ----------------------------------------------------------------------------
// rxf_pkg
// shared constants, register codes and types for the receive fifo
// ----------------------------------------------------------------------------
package rxf_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WM_W      = 5;
    localparam int FILL_W    = 5;
    localparam int CMP_W     = (CNT_W > WM_W) ? CNT_W : WM_W;
    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 4;
    localparam int PDATA_W   = 32;

    localparam logic [DATA_W-1:0] EMPTY_BYTE  = 8'hFE;
    localparam logic [WM_W-1:0]   UPPER_RESET = WM_W'((DEPTH * 3) / 4);
    localparam logic [WM_W-1:0]   LOWER_RESET = WM_W'(DEPTH / 4);

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_UPPER = 2'd0,
        REG_LOWER = 2'd1,
        REG_FLOW  = 2'd2
    } t_reg_idx;

    // operation code of an input item
    typedef enum logic {
        OP_RECEIVE = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    typedef struct packed {
        logic [WM_W-1:0] upper;
        logic [WM_W-1:0] lower;
        logic            flow_en;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] read_byte;
        logic              read_status;
        logic              overrun;
        logic              rts_n;
        logic [FILL_W-1:0] fill_count;
    } t_result;

endpackage

// ===== sv/rxf_regs.sv =====
// ----------------------------------------------------------------------------
// rxf_regs
// apb register file: watermarks and flow control enable
// ----------------------------------------------------------------------------
module rxf_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rxf_pkg::ADDR_W-1:0] paddr,
    input  logic [rxf_pkg::PDATA_W-1:0] pwdata,
    output logic [rxf_pkg::PDATA_W-1:0] prdata,
    output logic                       pready,
    output rxf_pkg::t_cfg              o_cfg
);
    import rxf_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper   <= UPPER_RESET;
            r_cfg.lower   <= LOWER_RESET;
            r_cfg.flow_en <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                REG_UPPER: r_cfg.upper   <= pwdata[WM_W-1:0];
                REG_LOWER: r_cfg.lower   <= pwdata[WM_W-1:0];
                REG_FLOW:  r_cfg.flow_en <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_UPPER: prdata = PDATA_W'(r_cfg.upper);
            REG_LOWER: prdata = PDATA_W'(r_cfg.lower);
            REG_FLOW:  prdata = PDATA_W'(r_cfg.flow_en);
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== sv/rxf_core.sv =====
// ----------------------------------------------------------------------------
// rxf_core
// byte store, pointers, fill count and rts state with the per-item logic
// ----------------------------------------------------------------------------
module rxf_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rxf_pkg::t_cfg              i_cfg,
    input  logic                       i_fire,
    input  logic                       i_op,
    input  logic [rxf_pkg::DATA_W-1:0] i_rx_byte,
    output rxf_pkg::t_result           o_res
);
    import rxf_pkg::*;

    logic [DATA_W-1:0] r_store [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rts, n_rts;
    logic              w_full, w_empty, w_push;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_push  = (t_op'(i_op) == OP_RECEIVE) && !w_full;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        n_rts   = r_rts;
        o_res   = '0;
        if (t_op'(i_op) == OP_RECEIVE) begin
            // rts check uses the count before the byte goes in
            if (i_cfg.flow_en && (CMP_W'(r_count) >= CMP_W'(i_cfg.upper))) begin
                n_rts = 1'b1;
            end
            if (!w_full) begin
                n_wptr  = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                n_count = r_count + 1'b1;
            end else begin
                o_res.overrun = 1'b1;
            end
        end else begin
            if (w_empty) begin
                o_res.read_byte   = EMPTY_BYTE;
                o_res.read_status = 1'b1;
            end else begin
                o_res.read_byte = r_store[r_rptr];
                n_rptr  = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                n_count = r_count - 1'b1;
                if (i_cfg.flow_en && (CMP_W'(n_count) < CMP_W'(i_cfg.lower))) begin
                    n_rts = 1'b0;
                end
            end
        end
        o_res.rts_n      = n_rts;
        o_res.fill_count = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_rts   <= 1'b0;
        end else if (i_fire) begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
            r_rts   <= n_rts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_push) begin
            r_store[r_wptr] <= i_rx_byte;
        end
    end

endmodule

// ===== sv/rx_fifo_with_rts_flow_control.sv =====
// ----------------------------------------------------------------------------
// rx_fifo_with_rts_flow_control
// receive byte fifo with watermark-driven active-low rts and apb setup port
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready     | i_op, i_rx_byte
//  out      | o_out_valid / i_out_ready   | o_read_byte, o_read_status,
//           |                             | o_overrun, o_rts_n, o_fill_count
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready = 1)
//
//  one item per cycle sustained while results are not stalled; an item's
//  result passes through the input register and then the result register
//  store access, count and rts update sit in the logic between them
//  synchronous active-low reset clears pointers, count, rts (active) and
//  both valid flags; watermarks reset to 3/4 and 1/4 of depth, flow on
//  a stalled result holds the item in the input register; new items are
//  still taken whenever the input register empties in the same cycle
// ----------------------------------------------------------------------------
module rx_fifo_with_rts_flow_control (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_op,
    input  logic [rxf_pkg::DATA_W-1:0]  i_rx_byte,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rxf_pkg::DATA_W-1:0]  o_read_byte,
    output logic                        o_read_status,
    output logic                        o_overrun,
    output logic                        o_rts_n,
    output logic [rxf_pkg::FILL_W-1:0]  o_fill_count,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rxf_pkg::ADDR_W-1:0]  paddr,
    input  logic [rxf_pkg::PDATA_W-1:0] pwdata,
    output logic [rxf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import rxf_pkg::*;

    t_cfg              w_cfg;
    t_result           w_res;
    t_result           r_res;

    // input register
    logic              r_in_valid;
    logic              r_in_op;
    logic [DATA_W-1:0] r_in_byte;

    // result register
    logic              r_out_valid;

    // item moves from input register into result register
    logic              w_fire;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    rxf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rxf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_fire    (w_fire),
        .i_op      (r_in_op),
        .i_rx_byte (r_in_byte),
        .o_res     (w_res)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op   <= i_op;
            r_in_byte <= i_rx_byte;
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_byte   = r_res.read_byte;
    assign o_read_status = r_res.read_status;
    assign o_overrun     = r_res.overrun;
    assign o_rts_n       = r_res.rts_n;
    assign o_fill_count  = r_res.fill_count;

endmodule

// ===== sv/rxf_checker.sv =====
// ----------------------------------------------------------------------------
// rxf_checker
// port-level checks on the receive fifo results
// ----------------------------------------------------------------------------
module rxf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [rxf_pkg::DATA_W-1:0]  o_read_byte,
    input logic                        o_read_status,
    input logic                        o_overrun,
    input logic [rxf_pkg::FILL_W-1:0]  o_fill_count
);
    import rxf_pkg::*;

    // stalled result holds its read byte and fill count
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_byte) && $stable(o_fill_count)))
        else $error("result changed while stalled");

    // count never exceeds depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CMP_W'(o_fill_count) <= CMP_W'(DEPTH)))
        else $error("fill count above depth");

    // dropped byte only when full, never with empty status
    a_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overrun) |->
            ((CMP_W'(o_fill_count) == CMP_W'(DEPTH)) && !o_read_status))
        else $error("overrun without full fifo");

    // empty read gives the marker byte and leaves nothing held
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_status) |->
            ((o_read_byte == EMPTY_BYTE) && (o_fill_count == '0)))
        else $error("bad empty read result");

endmodule

bind rx_fifo_with_rts_flow_control rxf_checker u_rxf_checker (.*);
